[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed in %m");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/irpdd_pkg.sv]
// ---------------------------------------------------------------------------
// irpdd_pkg
// shared widths, key code table and match result type of the ir decoder
// ---------------------------------------------------------------------------
`default_nettype none

package irpdd_pkg;

   localparam int CODE_BITS  = 16;             // bits in one remote code
   localparam int US_W       = 16;             // interval and window width
   localparam int RAW_W      = 16;             // raw code field width
   localparam int KEY_COUNT  = 12;
   localparam int KEY_IDX_W  = 4;
   localparam int KEY_W      = 32;             // width of stored key codes
   localparam int CNT_W      = $clog2(CODE_BITS);
   localparam int WIDE_W     = (CODE_BITS > RAW_W) ? CODE_BITS : RAW_W;

   // key codes in key index order: digits 0 to 9, mute, delete
   localparam logic [KEY_W-1:0] KEY_CODES [KEY_COUNT] = '{
      32'h0000_c004, 32'h0000_c084, 32'h0000_c044, 32'h0000_c0c4,
      32'h0000_c024, 32'h0000_c0a4, 32'h0000_c064, 32'h0000_c0e4,
      32'h0000_c014, 32'h0000_c094, 32'h0000_c0a0, 32'h0000_c038
   };

   typedef struct packed {
      logic                 matched;
      logic [KEY_IDX_W-1:0] index;
   } key_result_type;

endpackage : irpdd_pkg

`default_nettype wire

[src/irpdd_key_match.sv]
// ---------------------------------------------------------------------------
// irpdd_key_match
// compares a finished code with the twelve key codes, lowest index wins
// ---------------------------------------------------------------------------
`default_nettype none

module irpdd_key_match (
   input  wire logic [irpdd_pkg::CODE_BITS-1:0] code,
   output irpdd_pkg::key_result_type            result
);
   import irpdd_pkg::*;

   logic [KEY_W-1:0] code_ext;

   assign code_ext = KEY_W'(code);

   always_comb begin
      result = '0;
      // walk downwards so the lowest matching index is left standing
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (code_ext == KEY_CODES[i]) begin
            result.matched = 1'b1;
            result.index   = KEY_IDX_W'(i);
         end
      end
   end

endmodule : irpdd_key_match

`default_nettype wire

[src/ir_pulse_distance_decoder.sv]
// ---------------------------------------------------------------------------
// ir_pulse_distance_decoder
// pulse-distance ir remote decoder: header detect, 16 bit code, key match
// ---------------------------------------------------------------------------
// usage
//   req channel: one word per measured interval between rising edges of the
//     ir receiver; tdata carries the interval in microseconds, tuser the
//     timer wrap flag (a wrapped interval is dropped without effect)
//   rsp channel: one word per complete code, raw code plus key match
//   csr port: write-only window registers, taken on any edge with csr_we
//     high; only to be written while the decoder is idle
// response path: a response word shows on rsp_tvalid once the word carrying
//   the last bit has been taken into the input register and then decoded
//   into the result register
// throughput: one req word per cycle unless the output stalls; between those
//   registers the state update is one pass: window compares, shift, key compare
// stall: while rsp_tvalid waits on rsp_tready, one more req word is taken
//   into the input register, after which req_tready drops until the
//   response is taken
// reset: synchronous; windows return to 5000..15000 us (header) and
//   1500..2500 us (one bit), the decoder returns to idle, no word pending
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ir_pulse_distance_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] interval_us
   input  wire logic        req_tuser,    // [0] interval_overflow
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,    // [15:0] raw_code, [16] key_matched,
                                          // [20:17] key_index, [23:21] zero
   // configuration write port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import irpdd_pkg::*;

   // register indexes
   localparam logic [1:0] REG_HEADER_MIN = 2'd0;
   localparam logic [1:0] REG_HEADER_MAX = 2'd1;
   localparam logic [1:0] REG_ONE_MIN    = 2'd2;
   localparam logic [1:0] REG_ONE_MAX    = 2'd3;

   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(CODE_BITS - 1);

   // window registers
   logic [US_W-1:0] header_min_ff, header_max_ff, one_min_ff, one_max_ff;

   // input register
   logic            s1_valid_ff, s1_valid_in;
   logic [US_W-1:0] s1_interval_ff;
   logic            s1_overflow_ff;

   // decoder state
   logic                 receiving_ff, receiving_in;
   logic [CNT_W-1:0]     bits_ff, bits_in;
   logic [CODE_BITS-1:0] code_ff, code_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic [RAW_W-1:0] out_raw_ff;
   key_result_type   out_key_ff;

   logic                 req_accept;
   logic                 advance;      // output slot free for the s1 word
   logic                 take;         // s1 word acts on the state
   logic                 header_hit;
   logic                 bit_value;
   logic                 last_bit;
   logic                 emit;
   logic [CODE_BITS-1:0] code_next;
   logic [WIDE_W-1:0]    code_wide;
   key_result_type       key_result;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         header_min_ff <= US_W'(5000);
         header_max_ff <= US_W'(15000);
         one_min_ff    <= US_W'(1500);
         one_max_ff    <= US_W'(2500);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_HEADER_MIN: header_min_ff <= csr_wdata;
            REG_HEADER_MAX: header_max_ff <= csr_wdata;
            REG_ONE_MIN:    one_min_ff    <= csr_wdata;
            REG_ONE_MAX:    one_max_ff    <= csr_wdata;
            default:        header_min_ff <= header_min_ff;
         endcase
      end
   end

   // ---------------- handshakes ----------------
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   // ---------------- decode ----------------
   // a wrapped interval is dropped before it reaches the state
   assign take = s1_valid_ff && advance && !s1_overflow_ff;

   // strict window compares; a window with min >= max never hits
   assign header_hit = (s1_interval_ff > header_min_ff) && (s1_interval_ff < header_max_ff);
   assign bit_value  = (s1_interval_ff > one_min_ff) && (s1_interval_ff < one_max_ff);

   assign code_next = {code_ff[CODE_BITS-2:0], bit_value};
   assign last_bit  = (bits_ff == LAST_BIT);
   assign emit      = take && receiving_ff && last_bit;

   irpdd_key_match u_key_match (
      .code   (code_next),
      .result (key_result)
   );

   assign code_wide = WIDE_W'(code_next);

   always_comb begin
      receiving_in = receiving_ff;
      bits_in      = bits_ff;
      code_in      = code_ff;
      if (take) begin
         if (!receiving_ff) begin
            // idle: only a header interval starts a code
            if (header_hit) begin
               receiving_in = 1'b1;
               bits_in      = '0;
               code_in      = '0;
            end
         end else if (last_bit) begin
            receiving_in = 1'b0;
            bits_in      = '0;
            code_in      = '0;
         end else begin
            bits_in = bits_ff + CNT_W'(1);
            code_in = code_next;
         end
      end
   end

   always_comb begin
      if (emit)
         out_valid_in = 1'b1;
      else if (advance)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         receiving_ff <= 1'b0;
         bits_ff      <= '0;
         code_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         receiving_ff <= receiving_in;
         bits_ff      <= bits_in;
         code_ff      <= code_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_interval_ff <= req_tdata;
         s1_overflow_ff <= req_tuser;
      end
      if (emit) begin
         out_raw_ff <= code_wide[RAW_W-1:0];
         out_key_ff <= key_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_key_ff.index, out_key_ff.matched, out_raw_ff};

   // ---------------- assertions ----------------
   // bit count stays at zero while idle
   `ASSERT_IMPL(a_idle_count_zero, clock, reset, !receiving_ff, bits_ff == '0)
   // unmatched response carries a zero key index
   `ASSERT_IMPL(a_unmatched_index_zero, clock, reset,
                out_valid_ff && !out_key_ff.matched, out_key_ff.index == '0)
   // a response only follows a last bit taken while receiving
   `ASSERT_IMPL(a_rsp_from_last_bit, clock, reset,
                $rose(out_valid_ff), $past(emit))
   // a word parked in the input register stays while the output is blocked
   `ASSERT_NEXT(a_s1_held_on_stall, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule : ir_pulse_distance_decoder

`default_nettype wire
